@@ rtl/gaussian_integer_alu_defines.svh @@
// Assertion macros for the Gaussian integer ALU, used by its top-level file.
`ifndef GAUSSIAN_INTEGER_ALU_DEFINES_SVH
`define GAUSSIAN_INTEGER_ALU_DEFINES_SVH

// Same-cycle implication, sampled on clk and idle while rst_n is low.
`define GIA_ASSERT_IMPLY(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gaussian_integer_alu: check failed");

// Next-cycle implication, sampled on clk and idle while rst_n is low.
`define GIA_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gaussian_integer_alu: check failed");

`endif

@@ rtl/gia_pkg.sv @@
// Package with widths, operation codes, the context type and helpers of the Gaussian integer ALU.
`timescale 1ns / 1ps
package gia_pkg;

    localparam int PART_WIDTH = 16;
    localparam int KIND_WIDTH = 4;
    localparam int RES_WIDTH  = 33;
    localparam int PROD_WIDTH = 2 * PART_WIDTH;
    localparam int SUM_WIDTH  = 2 * PART_WIDTH + 1;
    localparam int MAG_WIDTH  = 2 * PART_WIDTH;
    localparam int QUO_WIDTH  = PART_WIDTH;
    localparam int QS_WIDTH   = PART_WIDTH + 2;
    localparam int DIV_WIDTH  = MAG_WIDTH + QUO_WIDTH;
    localparam int QP_WIDTH   = QS_WIDTH + PART_WIDTH;
    localparam int WIDE_WIDTH = 2 * PART_WIDTH + RES_WIDTH + 4;
    localparam int LANE_DEPTH = QUO_WIDTH + 1;
    localparam int PIPE_DEPTH = LANE_DEPTH + 4;

    localparam logic [KIND_WIDTH-1:0] KIND_ADD  = 4'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_SUB  = 4'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_MUL  = 4'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_DIV  = 4'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_REM  = 4'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_DVB  = 4'd5;
    localparam logic [KIND_WIDTH-1:0] KIND_EQ   = 4'd6;
    localparam logic [KIND_WIDTH-1:0] KIND_NEG  = 4'd7;
    localparam logic [KIND_WIDTH-1:0] KIND_CONJ = 4'd8;
    localparam logic [KIND_WIDTH-1:0] KIND_NORM = 4'd9;

    typedef logic signed [WIDE_WIDTH-1:0] wide_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]        kind;
        logic signed [PART_WIDTH-1:0] a_re;
        logic signed [PART_WIDTH-1:0] a_im;
        logic signed [PART_WIDTH-1:0] b_re;
        logic signed [PART_WIDTH-1:0] b_im;
        logic signed [RES_WIDTH-1:0]  res_re;
        logic signed [RES_WIDTH-1:0]  res_im;
        logic                         flag;
        logic                         fault;
    } ctx_t;

    function automatic logic signed [RES_WIDTH-1:0] to_res(input wide_t v);
        return v[RES_WIDTH-1:0];
    endfunction

    function automatic logic is_div_kind(input logic [KIND_WIDTH-1:0] k);
        return (k == KIND_DIV) || (k == KIND_REM) || (k == KIND_DVB);
    endfunction

endpackage

@@ rtl/gia_front.sv @@
// Front stages: simple results, the six part products and the sums that feed the dividers.
`timescale 1ns / 1ps
module gia_front
    import gia_pkg::*;
(
    input  logic                         clk,
    input  logic                         en,
    input  logic [KIND_WIDTH-1:0]        kind,
    input  logic signed [PART_WIDTH-1:0] a_real,
    input  logic signed [PART_WIDTH-1:0] a_imag,
    input  logic signed [PART_WIDTH-1:0] b_real,
    input  logic signed [PART_WIDTH-1:0] b_imag,
    output ctx_t                         ctx,
    output logic [MAG_WIDTH-1:0]         nr_mag,
    output logic                         nr_neg,
    output logic [MAG_WIDTH-1:0]         ni_mag,
    output logic                         ni_neg,
    output logic [MAG_WIDTH-1:0]         den
);

    ctx_t                         ctx1_next;
    ctx_t                         ctx1_reg;
    ctx_t                         ctx2_next;
    ctx_t                         ctx2_reg;
    logic signed [PART_WIDTH-1:0] y_re;
    logic signed [PART_WIDTH-1:0] y_im;
    logic signed [PROD_WIDTH-1:0] p1_reg;
    logic signed [PROD_WIDTH-1:0] p2_reg;
    logic signed [PROD_WIDTH-1:0] p3_reg;
    logic signed [PROD_WIDTH-1:0] p4_reg;
    logic signed [PROD_WIDTH-1:0] pb1_reg;
    logic signed [PROD_WIDTH-1:0] pb2_reg;
    logic signed [SUM_WIDTH-1:0]  nr;
    logic signed [SUM_WIDTH-1:0]  ni;
    logic signed [SUM_WIDTH-1:0]  dsum;
    logic [MAG_WIDTH-1:0]         nr_mag_reg;
    logic                         nr_neg_reg;
    logic [MAG_WIDTH-1:0]         ni_mag_reg;
    logic                         ni_neg_reg;
    logic [MAG_WIDTH-1:0]         den_reg;

    always_comb
    begin
        ctx1_next        = '0;
        ctx1_next.kind   = kind;
        ctx1_next.a_re   = a_real;
        ctx1_next.a_im   = a_imag;
        ctx1_next.b_re   = b_real;
        ctx1_next.b_im   = b_imag;
        case (kind)
            KIND_ADD:
            begin
                ctx1_next.res_re = to_res(WIDE_WIDTH'(a_real) + WIDE_WIDTH'(b_real));
                ctx1_next.res_im = to_res(WIDE_WIDTH'(a_imag) + WIDE_WIDTH'(b_imag));
            end
            KIND_SUB:
            begin
                ctx1_next.res_re = to_res(WIDE_WIDTH'(a_real) - WIDE_WIDTH'(b_real));
                ctx1_next.res_im = to_res(WIDE_WIDTH'(a_imag) - WIDE_WIDTH'(b_imag));
            end
            KIND_NEG:
            begin
                ctx1_next.res_re = to_res(-WIDE_WIDTH'(a_real));
                ctx1_next.res_im = to_res(-WIDE_WIDTH'(a_imag));
            end
            KIND_CONJ:
            begin
                ctx1_next.res_re = to_res(WIDE_WIDTH'(a_real));
                ctx1_next.res_im = to_res(-WIDE_WIDTH'(a_imag));
            end
            KIND_EQ:
            begin
                ctx1_next.flag = (a_real == b_real) && (a_imag == b_imag);
            end
            default:
            begin
                ctx1_next.flag = 1'b0;
            end
        endcase
        ctx1_next.fault = is_div_kind(kind) && (b_real == '0) && (b_imag == '0);
    end

    // The norm reuses the cross products with a in place of b.
    assign y_re = (kind == KIND_NORM) ? a_real : b_real;
    assign y_im = (kind == KIND_NORM) ? a_imag : b_imag;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx1_reg <= ctx1_next;
            p1_reg   <= a_real * y_re;
            p2_reg   <= a_imag * y_im;
            p3_reg   <= a_imag * y_re;
            p4_reg   <= a_real * y_im;
            pb1_reg  <= b_real * b_real;
            pb2_reg  <= b_imag * b_imag;
        end
    end

    assign nr   = SUM_WIDTH'(p1_reg) + SUM_WIDTH'(p2_reg);
    assign ni   = SUM_WIDTH'(p3_reg) - SUM_WIDTH'(p4_reg);
    assign dsum = SUM_WIDTH'(pb1_reg) + SUM_WIDTH'(pb2_reg);

    always_comb
    begin
        ctx2_next = ctx1_reg;
        case (ctx1_reg.kind)
            KIND_MUL:
            begin
                ctx2_next.res_re = to_res(WIDE_WIDTH'(p1_reg) - WIDE_WIDTH'(p2_reg));
                ctx2_next.res_im = to_res(WIDE_WIDTH'(p4_reg) + WIDE_WIDTH'(p3_reg));
            end
            KIND_NORM:
            begin
                ctx2_next.res_re = to_res(WIDE_WIDTH'(nr));
                ctx2_next.res_im = '0;
            end
            default:
            begin
                ctx2_next.flag = ctx1_reg.flag;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx2_reg   <= ctx2_next;
            nr_neg_reg <= nr[SUM_WIDTH-1];
            nr_mag_reg <= nr[SUM_WIDTH-1] ? MAG_WIDTH'(-nr) : MAG_WIDTH'(nr);
            ni_neg_reg <= ni[SUM_WIDTH-1];
            ni_mag_reg <= ni[SUM_WIDTH-1] ? MAG_WIDTH'(-ni) : MAG_WIDTH'(ni);
            den_reg    <= dsum[MAG_WIDTH-1:0];
        end
    end

    assign ctx    = ctx2_reg;
    assign nr_mag = nr_mag_reg;
    assign nr_neg = nr_neg_reg;
    assign ni_mag = ni_mag_reg;
    assign ni_neg = ni_neg_reg;
    assign den    = den_reg;

endmodule

@@ rtl/gia_div_lane.sv @@
// Pipelined restoring divider, one quotient bit per stage, with round-half-away and sign.
`timescale 1ns / 1ps
module gia_div_lane
    import gia_pkg::*;
(
    input  logic                       clk,
    input  logic                       en,
    input  logic [MAG_WIDTH-1:0]       mag,
    input  logic                       neg,
    input  logic [MAG_WIDTH-1:0]       den,
    output logic signed [QS_WIDTH-1:0] quo
);

    logic [MAG_WIDTH-1:0]       rem_reg [QUO_WIDTH];
    logic [MAG_WIDTH-1:0]       den_reg [QUO_WIDTH];
    logic [QUO_WIDTH-1:0]       quo_reg [QUO_WIDTH];
    logic                       neg_reg [QUO_WIDTH];
    logic                       up;
    logic [QUO_WIDTH:0]         qmag;
    logic signed [QS_WIDTH-1:0] quo_out_reg;

    for (genvar k = 0; k < QUO_WIDTH; k++)
    begin : g_stage
        logic [MAG_WIDTH-1:0] rem_in;
        logic [MAG_WIDTH-1:0] den_in;
        logic [QUO_WIDTH-1:0] quo_in;
        logic                 neg_in;
        logic [DIV_WIDTH-1:0] shifted;
        logic                 take;

        if (k == 0)
        begin : g_first
            assign rem_in = mag;
            assign den_in = den;
            assign quo_in = '0;
            assign neg_in = neg;
        end
        else
        begin : g_next
            assign rem_in = rem_reg[k-1];
            assign den_in = den_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign neg_in = neg_reg[k-1];
        end

        assign shifted = DIV_WIDTH'(den_in) << (QUO_WIDTH - 1 - k);
        assign take    = DIV_WIDTH'(rem_in) >= shifted;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k] <= take ? (rem_in - shifted[MAG_WIDTH-1:0]) : rem_in;
                quo_reg[k] <= quo_in | (QUO_WIDTH'(take) << (QUO_WIDTH - 1 - k));
                den_reg[k] <= den_in;
                neg_reg[k] <= neg_in;
            end
        end
    end

    assign up   = {rem_reg[QUO_WIDTH-1], 1'b0} >= {1'b0, den_reg[QUO_WIDTH-1]};
    assign qmag = {1'b0, quo_reg[QUO_WIDTH-1]} + (QUO_WIDTH + 1)'(up);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_out_reg <= neg_reg[QUO_WIDTH-1] ? -QS_WIDTH'(qmag) : QS_WIDTH'(qmag);
        end
    end

    assign quo = quo_out_reg;

endmodule

@@ rtl/gia_back.sv @@
// Back stages: quotient times divisor, remainder, divisibility test and the output register.
`timescale 1ns / 1ps
module gia_back
    import gia_pkg::*;
(
    input  logic                        clk,
    input  logic                        en,
    input  ctx_t                        ctx,
    input  logic signed [QS_WIDTH-1:0]  qr,
    input  logic signed [QS_WIDTH-1:0]  qi,
    output logic signed [RES_WIDTH-1:0] res_real,
    output logic signed [RES_WIDTH-1:0] res_imag,
    output logic                        flag,
    output logic                        fault
);

    ctx_t                        ctx_reg;
    logic signed [QS_WIDTH-1:0]  qr_reg;
    logic signed [QS_WIDTH-1:0]  qi_reg;
    logic signed [QP_WIDTH-1:0]  m1_reg;
    logic signed [QP_WIDTH-1:0]  m2_reg;
    logic signed [QP_WIDTH-1:0]  m3_reg;
    logic signed [QP_WIDTH-1:0]  m4_reg;
    wide_t                       mr;
    wide_t                       mi;
    logic signed [RES_WIDTH-1:0] res_re_next;
    logic signed [RES_WIDTH-1:0] res_im_next;
    logic                        flag_next;
    logic signed [RES_WIDTH-1:0] res_re_reg;
    logic signed [RES_WIDTH-1:0] res_im_reg;
    logic                        flag_reg;
    logic                        fault_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctx_reg <= ctx;
            qr_reg  <= qr;
            qi_reg  <= qi;
            m1_reg  <= qr * ctx.b_re;
            m2_reg  <= qi * ctx.b_im;
            m3_reg  <= qr * ctx.b_im;
            m4_reg  <= qi * ctx.b_re;
        end
    end

    assign mr = WIDE_WIDTH'(ctx_reg.a_re) - (WIDE_WIDTH'(m1_reg) - WIDE_WIDTH'(m2_reg));
    assign mi = WIDE_WIDTH'(ctx_reg.a_im) - (WIDE_WIDTH'(m3_reg) + WIDE_WIDTH'(m4_reg));

    always_comb
    begin
        res_re_next = ctx_reg.res_re;
        res_im_next = ctx_reg.res_im;
        flag_next   = ctx_reg.flag;
        if (!ctx_reg.fault)
        begin
            case (ctx_reg.kind)
                KIND_DIV:
                begin
                    res_re_next = to_res(WIDE_WIDTH'(qr_reg));
                    res_im_next = to_res(WIDE_WIDTH'(qi_reg));
                end
                KIND_REM:
                begin
                    res_re_next = to_res(mr);
                    res_im_next = to_res(mi);
                end
                KIND_DVB:
                begin
                    flag_next = (mr == '0) && (mi == '0);
                end
                default:
                begin
                    flag_next = ctx_reg.flag;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            res_re_reg <= res_re_next;
            res_im_reg <= res_im_next;
            flag_reg   <= flag_next;
            fault_reg  <= ctx_reg.fault;
        end
    end

    assign res_real = res_re_reg;
    assign res_imag = res_im_reg;
    assign flag     = flag_reg;
    assign fault    = fault_reg;

endmodule

@@ rtl/gaussian_integer_alu.sv @@
// Gaussian integer ALU: add, subtract, multiply, rounded divide, remainder, tests, negate,
// conjugate and norm. It takes one word per cycle while in_stall is low and returns the
// results in order through the front stages, the two divider lanes and the back stages. The depth
// comes from the two restoring dividers, which settle one quotient bit per stage. When the
// output word is stalled the whole pipeline holds and in_stall rises.
`timescale 1ns / 1ps
`include "gaussian_integer_alu_defines.svh"
module gaussian_integer_alu
    import gia_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [KIND_WIDTH-1:0]       kind,
    input  logic signed [PART_WIDTH-1:0] a_real,
    input  logic signed [PART_WIDTH-1:0] a_imag,
    input  logic signed [PART_WIDTH-1:0] b_real,
    input  logic signed [PART_WIDTH-1:0] b_imag,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic signed [RES_WIDTH-1:0] res_real,
    output logic signed [RES_WIDTH-1:0] res_imag,
    output logic                        flag,
    output logic                        fault
);

    logic                       adv;
    logic                       vld_reg [PIPE_DEPTH];
    ctx_t                       ctx_reg [LANE_DEPTH];
    ctx_t                       front_ctx;
    logic [MAG_WIDTH-1:0]       nr_mag;
    logic                       nr_neg;
    logic [MAG_WIDTH-1:0]       ni_mag;
    logic                       ni_neg;
    logic [MAG_WIDTH-1:0]       den;
    logic signed [QS_WIDTH-1:0] qr;
    logic signed [QS_WIDTH-1:0] qi;

    assign adv      = !vld_reg[PIPE_DEPTH-1] || !out_stall;
    assign in_stall = !adv;
    assign out_valid = vld_reg[PIPE_DEPTH-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (adv)
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    gia_front u_front (
        .clk    (clk),
        .en     (adv),
        .kind   (kind),
        .a_real (a_real),
        .a_imag (a_imag),
        .b_real (b_real),
        .b_imag (b_imag),
        .ctx    (front_ctx),
        .nr_mag (nr_mag),
        .nr_neg (nr_neg),
        .ni_mag (ni_mag),
        .ni_neg (ni_neg),
        .den    (den)
    );

    gia_div_lane u_div_re (
        .clk (clk),
        .en  (adv),
        .mag (nr_mag),
        .neg (nr_neg),
        .den (den),
        .quo (qr)
    );

    gia_div_lane u_div_im (
        .clk (clk),
        .en  (adv),
        .mag (ni_mag),
        .neg (ni_neg),
        .den (den),
        .quo (qi)
    );

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            ctx_reg[0] <= front_ctx;
            for (int i = 1; i < LANE_DEPTH; i++)
            begin
                ctx_reg[i] <= ctx_reg[i-1];
            end
        end
    end

    gia_back u_back (
        .clk      (clk),
        .en       (adv),
        .ctx      (ctx_reg[LANE_DEPTH-1]),
        .qr       (qr),
        .qi       (qi),
        .res_real (res_real),
        .res_imag (res_imag),
        .flag     (flag),
        .fault    (fault)
    );

    `GIA_ASSERT_IMPLY(a_fault_zero, out_valid && fault, (res_real == '0) && (res_imag == '0) && !flag)
    `GIA_ASSERT_IMPLY(a_flag_zero, out_valid && flag, (res_real == '0) && (res_imag == '0))
    `GIA_ASSERT_IMPLY(a_stall_full, in_stall, out_valid && out_stall)

endmodule

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the Gaussian integer ALU: directed table, random words, prediction.
`timescale 1ns / 1ps
module tb_top;
    import gia_pkg::*;

    localparam int LATENCY   = PIPE_DEPTH;
    localparam int N_RANDOM  = 800;
    localparam int MAX_CYCLE = 200000;

    typedef struct {
        logic [KIND_WIDTH-1:0]        kind;
        logic signed [PART_WIDTH-1:0] ar, ai, br, bi;
        logic                         known;
        logic signed [RES_WIDTH-1:0]  rr, ri;
        logic                         fl, ft;
    } row_t;

    typedef struct {
        logic signed [RES_WIDTH-1:0] rr, ri;
        logic                        fl, ft;
    } gauss_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [KIND_WIDTH-1:0] kind = '0;
    logic signed [PART_WIDTH-1:0] a_real = '0, a_imag = '0, b_real = '0, b_imag = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [RES_WIDTH-1:0] res_real, res_imag;
    logic flag, fault;

    gauss_res_t pending_results[$];
    int errors = 0;
    int cycles = 0;
    int results_seen = 0;
    int words_sent = 0;
    bit sending_done = 1'b0;
    int out_wait = 0;
    bit draw_wait = 1'b1;

    gaussian_integer_alu u_top (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Rounds n / d to nearest, ties away from zero; d is positive.
    function automatic longint round_quot(input longint n, input longint d);
        longint m, q, r;
        m = (n < 0) ? -n : n;
        q = m / d;
        r = m % d;
        if (r >= d - r)
            q++;
        return (n < 0) ? -q : q;
    endfunction

    function automatic gauss_res_t gauss_compute(input logic [KIND_WIDTH-1:0] k,
        input longint ar, input longint ai, input longint br, input longint bi);
        gauss_res_t g;
        longint rr, ri, den, qr, qi, mr, mi;
        rr = 0;
        ri = 0;
        g.fl = 1'b0;
        g.ft = 1'b0;
        case (k)
            KIND_ADD:
            begin
                rr = ar + br;
                ri = ai + bi;
            end
            KIND_SUB:
            begin
                rr = ar - br;
                ri = ai - bi;
            end
            KIND_MUL:
            begin
                rr = ar * br - ai * bi;
                ri = ar * bi + ai * br;
            end
            KIND_DIV, KIND_REM, KIND_DVB:
            begin
                den = br * br + bi * bi;
                if (den == 0)
                    g.ft = 1'b1;
                else
                begin
                    qr = round_quot(ar * br + ai * bi, den);
                    qi = round_quot(ai * br - ar * bi, den);
                    mr = ar - (qr * br - qi * bi);
                    mi = ai - (qr * bi + qi * br);
                    if (k == KIND_DIV)
                    begin
                        rr = qr;
                        ri = qi;
                    end
                    else if (k == KIND_REM)
                    begin
                        rr = mr;
                        ri = mi;
                    end
                    else
                        g.fl = (mr == 0 && mi == 0);
                end
            end
            KIND_EQ: g.fl = (ar == br && ai == bi);
            KIND_NEG:
            begin
                rr = -ar;
                ri = -ai;
            end
            KIND_CONJ:
            begin
                rr = ar;
                ri = -ai;
            end
            KIND_NORM: rr = ar * ar + ai * ai;
            default: ;
        endcase
        g.rr = rr[RES_WIDTH-1:0];
        g.ri = ri[RES_WIDTH-1:0];
        return g;
    endfunction

    task automatic send_word(input row_t w);
        gauss_res_t g;
        int gap;
        gap = $urandom_range(0, 8);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        g = gauss_compute(w.kind, w.ar, w.ai, w.br, w.bi);
        if (w.known)
        begin
            g.rr = w.rr;
            g.ri = w.ri;
            g.fl = w.fl;
            g.ft = w.ft;
        end
        in_valid <= 1'b1;
        kind <= w.kind;
        a_real <= w.ar;
        a_imag <= w.ai;
        b_real <= w.br;
        b_imag <= w.bi;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_results.push_back(g);
        words_sent++;
        @(negedge clk);
    endtask

    function automatic row_t mk(input logic [KIND_WIDTH-1:0] k, input int ar, input int ai,
        input int br, input int bi);
        row_t w;
        w.kind = k;
        w.ar = PART_WIDTH'(ar);
        w.ai = PART_WIDTH'(ai);
        w.br = PART_WIDTH'(br);
        w.bi = PART_WIDTH'(bi);
        w.known = 1'b0;
        w.rr = '0;
        w.ri = '0;
        w.fl = 1'b0;
        w.ft = 1'b0;
        return w;
    endfunction

    function automatic row_t mkx(input row_t w, input longint rr, input longint ri,
        input logic fl, input logic ft);
        w.known = 1'b1;
        w.rr = rr[RES_WIDTH-1:0];
        w.ri = ri[RES_WIDTH-1:0];
        w.fl = fl;
        w.ft = ft;
        return w;
    endfunction

    function automatic logic signed [PART_WIDTH-1:0] rand_part();
        case ($urandom_range(0, 5))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2: return $signed(16'($urandom_range(0, 6))) - 16'sd3;
            3: return $signed(16'($urandom_range(0, 200))) - 16'sd100;
            default: return 16'($urandom);
        endcase
    endfunction

    initial
    begin
        row_t table_rows[$];
        row_t w;
        int ar, ai, br, bi;
        table_rows.push_back(mkx(mk(KIND_ADD, 32767, 32767, 32767, 32767), 65534, 65534, 0, 0));
        table_rows.push_back(mkx(mk(KIND_ADD, -32768, -32768, -32768, -32768),
            -65536, -65536, 0, 0));
        table_rows.push_back(mkx(mk(KIND_SUB, -32768, 32767, 32767, -32768),
            -65535, 65535, 0, 0));
        table_rows.push_back(mkx(mk(KIND_MUL, -32768, -32768, -32768, 32767),
            2147450880, 32768, 0, 0));
        table_rows.push_back(mk(KIND_MUL, 32767, -32768, 123, -456));
        table_rows.push_back(mkx(mk(KIND_DIV, 5, 7, 0, 0), 0, 0, 0, 1));
        table_rows.push_back(mkx(mk(KIND_REM, -32768, 1, 0, 0), 0, 0, 0, 1));
        table_rows.push_back(mkx(mk(KIND_DVB, 3, 3, 0, 0), 0, 0, 0, 1));
        table_rows.push_back(mk(KIND_DIV, 1, 0, 2, 0));
        table_rows.push_back(mk(KIND_DIV, -1, 0, 2, 0));
        table_rows.push_back(mk(KIND_DIV, -32768, -32768, 1, 1));
        table_rows.push_back(mk(KIND_DIV, 32767, -32768, -32768, -32768));
        table_rows.push_back(mk(KIND_REM, 7, 3, 2, -1));
        table_rows.push_back(mk(KIND_REM, -32768, 32767, 3, 5));
        table_rows.push_back(mk(KIND_DVB, 5, 5, 1, 2));
        table_rows.push_back(mk(KIND_DVB, 5, 0, 1, 2));
        table_rows.push_back(mkx(mk(KIND_EQ, -32768, 32767, -32768, 32767), 0, 0, 1, 0));
        table_rows.push_back(mkx(mk(KIND_EQ, 1, 2, 1, 3), 0, 0, 0, 0));
        table_rows.push_back(mkx(mk(KIND_NEG, -32768, 32767, 0, 0), 32768, -32767, 0, 0));
        table_rows.push_back(mkx(mk(KIND_CONJ, 32767, -32768, 9, 9), 32767, 32768, 0, 0));
        table_rows.push_back(mkx(mk(KIND_NORM, -32768, -32768, 1, 1),
            64'sd2147483648, 0, 0, 0));
        table_rows.push_back(mkx(mk(4'd10, 5, 5, 5, 5), 0, 0, 0, 0));
        table_rows.push_back(mkx(mk(4'd15, -1, -1, -1, -1), 0, 0, 0, 0));

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        foreach (table_rows[i])
            send_word(table_rows[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == N_RANDOM / 2)
            begin
                in_valid <= 1'b0;
                wait (pending_results.size() == 0);
                @(negedge clk);
            end
            ar = rand_part();
            ai = rand_part();
            br = rand_part();
            bi = rand_part();
            w = mk(4'($urandom_range(0, 15)), ar, ai, br, bi);
            if ($urandom_range(0, 9) < 8)
                w.kind = 4'($urandom_range(0, 9));
            if ($urandom_range(0, 9) == 0)
            begin
                w.br = '0;
                w.bi = '0;
            end
            else if (w.kind == KIND_DVB && $urandom_range(0, 1) == 1)
            begin
                // A multiple of b, so that the test is true often enough.
                ar = $signed(16'($urandom_range(0, 20))) - 10;
                ai = $signed(16'($urandom_range(0, 20))) - 10;
                br = $signed(16'($urandom_range(0, 200))) - 100;
                bi = $signed(16'($urandom_range(0, 200))) - 100;
                w.br = PART_WIDTH'(br);
                w.bi = PART_WIDTH'(bi);
                w.ar = PART_WIDTH'(ar * br - ai * bi);
                w.ai = PART_WIDTH'(ar * bi + ai * br);
            end
            else if (w.kind == KIND_EQ && $urandom_range(0, 1) == 1)
            begin
                w.br = w.ar;
                w.bi = w.ai;
            end
            send_word(w);
        end
        in_valid <= 1'b0;
        sending_done = 1'b1;
    end

    always @(negedge clk)
    begin
        if (draw_wait)
        begin
            out_wait = $urandom_range(0, 8);
            draw_wait = 1'b0;
        end
        if (out_wait > 0)
        begin
            out_stall <= 1'b1;
            out_wait--;
        end
        else
            out_stall <= 1'b0;
    end

    always @(posedge clk)
    begin
        gauss_res_t g;
        cycles <= cycles + 1;
        if (rst_n && out_valid && !out_stall)
        begin
            draw_wait = 1'b1;
            if (pending_results.size() == 0)
            begin
                $error("result word with nothing expected");
                errors++;
            end
            else
            begin
                g = pending_results.pop_front();
                results_seen++;
                if (res_real !== g.rr)
                begin
                    $error("res_real expected %0d got %0d", g.rr, res_real);
                    errors++;
                end
                if (res_imag !== g.ri)
                begin
                    $error("res_imag expected %0d got %0d", g.ri, res_imag);
                    errors++;
                end
                if (flag !== g.fl)
                begin
                    $error("flag expected %0b got %0b", g.fl, flag);
                    errors++;
                end
                if (fault !== g.ft)
                begin
                    $error("fault expected %0b got %0b", g.ft, fault);
                    errors++;
                end
            end
        end
    end

    initial
    begin
        wait (sending_done && pending_results.size() == 0);
        repeat (LATENCY + 10) @(posedge clk);
        $display("Sent %0d words over all operation codes, checked %0d results.",
            words_sent, results_seen);
        if (errors == 0 && pending_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        wait (cycles >= MAX_CYCLE);
        $display("Run timed out after %0d cycles.", cycles);
        $display("tb_top NOT OK");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/gia_pkg.sv
rtl/gia_front.sv
rtl/gia_div_lane.sv
rtl/gia_back.sv
rtl/gaussian_integer_alu.sv
tb/sv/tb_top.sv
